[rtl/vrp_pkg.sv]
// Package for the 2D vector rectangular/polar unit: widths, fixed-point
// constants, opcodes, the CORDIC arctangent table and the pipeline lane type.
// Depends on nothing.
package vrp_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int XW = 50;         // working x/y width, Q32 with headroom
  localparam int ZW = 34;         // angle accumulator width, Q30
  localparam int RW = 46;         // magnitude of the Q30 input angle
  localparam int RED_STEPS = 13;  // restoring steps of the angle reduction

  localparam logic signed [31:0]    K_Q30       = 32'sd652032874;
  localparam logic signed [ZW-1:0]  PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0]  HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0]  TWO_PI_Q30  = 34'sd6746518852;
  localparam logic [RW-1:0]         TWO_PI_RED  = 46'd6746518852;
  localparam logic signed [19:0]    ANGLE_LIMIT = 20'sd205888;
  localparam logic signed [31:0]    I32_MAX     = 32'sh7fffffff;
  localparam logic signed [31:0]    I32_MIN     = 32'sh80000000;

  typedef enum logic [2:0] {
    OP_PASS  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_NEG   = 3'd3,
    OP_SCALE = 3'd4,
    OP_POLAR = 3'd5
  } op_t;

  // atan(2^-i) in Q30, truncated.
  localparam logic [29:0] ATAN_TAB [31] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
    30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
    30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
    30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1
  };

  // Everything one item carries down the pipeline.
  typedef struct packed {
    logic [2:0]              op;
    logic                    sat;
    logic                    flip;
    logic                    neg;
    logic                    zero;
    logic signed [31:0]      rx;
    logic signed [31:0]      ry;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ZW-1:0]    z;
    logic [RW-1:0]           red;
  } lane_t;

  function automatic logic signed [31:0] clip32(input logic signed [XW-1:0] v);
    logic signed [31:0] r;
    if (v > XW'(I32_MAX)) begin
      r = I32_MAX;
    end else if (v < XW'(I32_MIN)) begin
      r = I32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [XW-1:0] v);
    return (v > XW'(I32_MAX)) || (v < XW'(I32_MIN));
  endfunction

endpackage

[rtl/vrp_ifs.sv]
// Valid/ready channel interfaces of the 2D vector unit, input and result side.
// Depends on nothing.
interface vrp_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] factor;

  modport source (output valid, op, a_x, a_y, b_x, b_y, factor, input ready);
  modport sink (input valid, op, a_x, a_y, b_x, b_y, factor, output ready);
endinterface

interface vrp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic [30:0]        magnitude;
  logic signed [18:0] angle;
  logic               saturated;

  modport source (output valid, res_x, res_y, magnitude, angle, saturated, input ready);
  modport sink (input valid, res_x, res_y, magnitude, angle, saturated, output ready);
endinterface

[rtl/vrp_mod_cell.sv]
// One restoring step of the angle reduction modulo 2*pi.
// Depends on vrp_pkg.
module vrp_mod_cell
  import vrp_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  lane_t in_lane,
  output logic  valid_r,
  output lane_t lane_r
);

  localparam logic [RW-1:0] STEP = TWO_PI_RED << (RED_STEPS - 1 - STAGE);

  lane_t lane_nxt;

  always_comb begin
    lane_nxt = in_lane;
    if (in_lane.red >= STEP) begin
      lane_nxt.red = in_lane.red - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

[rtl/vrp_cordic_cell.sv]
// One CORDIC micro-rotation with a fixed shift, rotating or vectoring.
// Depends on vrp_pkg.
module vrp_cordic_cell
  import vrp_pkg::*;
#(
  parameter int STAGE     = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  lane_t in_lane,
  output logic  valid_r,
  output lane_t lane_r
);

  localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[STAGE]);

  lane_t                lane_nxt;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic                 pos;

  always_comb begin
    lane_nxt = in_lane;
    xs       = in_lane.x >>> STAGE;
    ys       = in_lane.y >>> STAGE;
    pos      = VECTORING ? (in_lane.y >= 0) : (in_lane.z >= 0);
    // Vectoring drives y toward zero; rotating drives z toward zero.
    if (pos ^ VECTORING) begin
      lane_nxt.x = in_lane.x - ys;
      lane_nxt.y = in_lane.y + xs;
      lane_nxt.z = in_lane.z - ANG;
    end else begin
      lane_nxt.x = in_lane.x + ys;
      lane_nxt.y = in_lane.y - xs;
      lane_nxt.z = in_lane.z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

[rtl/vector2d_rect_polar_unit_top.sv]
// Top level of the 2D vector rectangular/polar unit.
// Depends on vrp_pkg, vrp_ifs, vrp_mod_cell and vrp_cordic_cell.
//
// The unit applies one vector operation per beat (pass, add, subtract, negate,
// scale, or build from polar magnitude and angle) on signed Q16.16 values and
// returns the result vector with its magnitude and atan2 angle. It is a
// straight pipeline of 2*CORDIC_STEPS + 20 register stages: input and product
// registers, a stage for the rectangular results, thirteen cells that reduce
// the polar angle modulo 2*pi, a fold stage, CORDIC_STEPS rotating cells, a
// merge and saturation stage, a multiply and a setup stage for the gain
// correction, CORDIC_STEPS vectoring cells and the output register. It accepts
// one beat every cycle while the pipeline is not held. All stages advance
// together; the whole pipeline holds only while a result waits in the output
// register and the sink is not ready. Unused opcodes give the zero vector.
module vector2d_rect_polar_unit_top
  import vrp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  vrp_in_if.sink     in_ch,
  vrp_out_if.source  out_ch
);

  logic en;

  // Input stage: operands and the three products.
  logic               f1_valid_r;
  logic [2:0]         f1_op_r;
  logic signed [31:0] f1_ax_r;
  logic signed [31:0] f1_ay_r;
  logic signed [31:0] f1_bx_r;
  logic signed [31:0] f1_by_r;
  logic signed [63:0] f1_px_r;
  logic signed [63:0] f1_py_r;
  logic signed [61:0] f1_mk_r;

  logic signed [63:0] px_nxt;
  logic signed [63:0] py_nxt;
  logic signed [61:0] mk_nxt;

  // Out register.
  logic               out_valid_r;
  logic signed [31:0] res_x_r;
  logic signed [31:0] res_y_r;
  logic [30:0]        mag_r;
  logic signed [18:0] ang_r;
  logic               sat_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  assign px_nxt = in_ch.factor * in_ch.a_x;
  assign py_nxt = in_ch.factor * in_ch.a_y;
  assign mk_nxt = in_ch.a_x * K_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_op_r <= in_ch.op;
      f1_ax_r <= in_ch.a_x;
      f1_ay_r <= in_ch.a_y;
      f1_bx_r <= in_ch.b_x;
      f1_by_r <= in_ch.b_y;
      f1_px_r <= px_nxt;
      f1_py_r <= py_nxt;
      f1_mk_r <= mk_nxt;
    end
  end

  // Second stage: rectangular results, polar prescale and the angle magnitude.
  lane_t              red_lane [RED_STEPS+1];
  logic               red_v    [RED_STEPS+1];
  lane_t              l0_nxt;
  logic signed [XW-1:0] pre_x;
  logic signed [XW-1:0] pre_y;
  logic signed [63:0] sc_x;
  logic signed [63:0] sc_y;
  logic signed [61:0] mk_rnd;
  logic [31:0]        th_abs;

  always_comb begin
    sc_x   = (f1_px_r + 64'sd32768) >>> 16;
    sc_y   = (f1_py_r + 64'sd32768) >>> 16;
    mk_rnd = (f1_mk_r + 62'sd8192) >>> 14;
    unique case (op_t'(f1_op_r))
      OP_PASS: begin
        pre_x = XW'(f1_ax_r);
        pre_y = XW'(f1_ay_r);
      end
      OP_ADD: begin
        pre_x = XW'(f1_ax_r) + XW'(f1_bx_r);
        pre_y = XW'(f1_ay_r) + XW'(f1_by_r);
      end
      OP_SUB: begin
        pre_x = XW'(f1_ax_r) - XW'(f1_bx_r);
        pre_y = XW'(f1_ay_r) - XW'(f1_by_r);
      end
      OP_NEG: begin
        pre_x = -XW'(f1_ax_r);
        pre_y = -XW'(f1_ay_r);
      end
      OP_SCALE: begin
        pre_x = sc_x[XW-1:0];
        pre_y = sc_y[XW-1:0];
      end
      default: begin
        pre_x = '0;
        pre_y = '0;
      end
    endcase
    th_abs      = f1_ay_r[31] ? 32'(-f1_ay_r) : 32'(f1_ay_r);
    l0_nxt      = '0;
    l0_nxt.op   = f1_op_r;
    l0_nxt.rx   = clip32(pre_x);
    l0_nxt.ry   = clip32(pre_y);
    l0_nxt.sat  = ovf32(pre_x) || ovf32(pre_y);
    l0_nxt.x    = mk_rnd[XW-1:0];
    l0_nxt.neg  = f1_ay_r[31];
    l0_nxt.red  = {th_abs, 14'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_v[0] <= 1'b0;
    end else if (en) begin
      red_v[0] <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_lane[0] <= l0_nxt;
    end
  end

  for (genvar i = 0; i < RED_STEPS; i++) begin : g_red
    vrp_mod_cell #(.STAGE(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (red_v[i]),
      .in_lane  (red_lane[i]),
      .valid_r  (red_v[i+1]),
      .lane_r   (red_lane[i+1])
    );
  end

  // Fold the reduced angle into [-pi/2, pi/2], noting a half-turn flip.
  lane_t               rot_lane [CORDIC_STEPS+1];
  logic                rot_v    [CORDIC_STEPS+1];
  lane_t               fold_nxt;
  logic signed [ZW-1:0] za;
  logic signed [ZW-1:0] zs;
  logic signed [ZW-1:0] z1;

  always_comb begin
    fold_nxt = red_lane[RED_STEPS];
    za       = ZW'(red_lane[RED_STEPS].red);
    zs       = red_lane[RED_STEPS].neg ? -za : za;
    if (zs > PI_Q30) begin
      z1 = zs - TWO_PI_Q30;
    end else if (zs < -PI_Q30) begin
      z1 = zs + TWO_PI_Q30;
    end else begin
      z1 = zs;
    end
    fold_nxt.flip = 1'b0;
    fold_nxt.z    = z1;
    fold_nxt.y    = '0;
    if (z1 > HALF_PI_Q30) begin
      fold_nxt.z    = z1 - PI_Q30;
      fold_nxt.flip = 1'b1;
    end else if (z1 < -HALF_PI_Q30) begin
      fold_nxt.z    = z1 + PI_Q30;
      fold_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_v[0] <= 1'b0;
    end else if (en) begin
      rot_v[0] <= red_v[RED_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_lane[0] <= fold_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    vrp_cordic_cell #(.STAGE(i), .VECTORING(1'b0)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (rot_v[i]),
      .in_lane  (rot_lane[i]),
      .valid_r  (rot_v[i+1]),
      .lane_r   (rot_lane[i+1])
    );
  end

  // Merge: the polar result replaces the rectangular one for its opcode.
  logic                 mg_valid_r;
  lane_t                mg_lane_r;
  lane_t                mg_nxt;
  logic signed [XW-1:0] xf;
  logic signed [XW-1:0] yf;
  logic signed [XW-1:0] qx;
  logic signed [XW-1:0] qy;

  always_comb begin
    mg_nxt = rot_lane[CORDIC_STEPS];
    xf     = rot_lane[CORDIC_STEPS].flip ? -rot_lane[CORDIC_STEPS].x
                                         : rot_lane[CORDIC_STEPS].x;
    yf     = rot_lane[CORDIC_STEPS].flip ? -rot_lane[CORDIC_STEPS].y
                                         : rot_lane[CORDIC_STEPS].y;
    qx     = (xf + 50'sd32768) >>> 16;
    qy     = (yf + 50'sd32768) >>> 16;
    if (op_t'(rot_lane[CORDIC_STEPS].op) == OP_POLAR) begin
      mg_nxt.rx  = clip32(qx);
      mg_nxt.ry  = clip32(qy);
      mg_nxt.sat = ovf32(qx) || ovf32(qy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mg_valid_r <= 1'b0;
    end else if (en) begin
      mg_valid_r <= rot_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mg_lane_r <= mg_nxt;
    end
  end

  // Gain correction products for the vectoring pass.
  logic               mu_valid_r;
  lane_t              mu_lane_r;
  logic signed [61:0] mu_px_r;
  logic signed [61:0] mu_py_r;
  logic signed [61:0] mu_px_nxt;
  logic signed [61:0] mu_py_nxt;

  assign mu_px_nxt = mg_lane_r.rx * K_Q30;
  assign mu_py_nxt = mg_lane_r.ry * K_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_valid_r <= 1'b0;
    end else if (en) begin
      mu_valid_r <= mg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_lane_r <= mg_lane_r;
      mu_px_r   <= mu_px_nxt;
      mu_py_r   <= mu_py_nxt;
    end
  end

  // Vectoring setup: left half-plane vectors are turned by pi first.
  lane_t              vec_lane [CORDIC_STEPS+1];
  logic               vec_v    [CORDIC_STEPS+1];
  lane_t              v0_nxt;
  logic signed [61:0] vx_rnd;
  logic signed [61:0] vy_rnd;

  always_comb begin
    v0_nxt      = mu_lane_r;
    vx_rnd      = (mu_px_r + 62'sd8192) >>> 14;
    vy_rnd      = (mu_py_r + 62'sd8192) >>> 14;
    v0_nxt.zero = (mu_lane_r.rx == 0) && (mu_lane_r.ry == 0);
    if (mu_lane_r.rx < 0) begin
      v0_nxt.x = -vx_rnd[XW-1:0];
      v0_nxt.y = -vy_rnd[XW-1:0];
      v0_nxt.z = (mu_lane_r.ry >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      v0_nxt.x = vx_rnd[XW-1:0];
      v0_nxt.y = vy_rnd[XW-1:0];
      v0_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_v[0] <= 1'b0;
    end else if (en) begin
      vec_v[0] <= mu_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_lane[0] <= v0_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    vrp_cordic_cell #(.STAGE(i), .VECTORING(1'b1)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (vec_v[i]),
      .in_lane  (vec_lane[i]),
      .valid_r  (vec_v[i+1]),
      .lane_r   (vec_lane[i+1])
    );
  end

  // Output stage: round magnitude and angle, saturate and clamp.
  lane_t                fin;
  logic signed [XW-1:0] mq;
  logic signed [ZW-1:0] aq;
  logic [30:0]          mag_nxt;
  logic signed [18:0]   ang_nxt;
  logic                 msat;

  always_comb begin
    fin  = vec_lane[CORDIC_STEPS];
    mq   = (fin.x + 50'sd32768) >>> 16;
    aq   = (fin.z + 34'sd8192) >>> 14;
    msat = 1'b0;
    if (fin.zero) begin
      mag_nxt = '0;
      ang_nxt = '0;
    end else begin
      if (mq < 0) begin
        mag_nxt = '0;
      end else if (mq > XW'(I32_MAX)) begin
        mag_nxt = '1;
        msat    = 1'b1;
      end else begin
        mag_nxt = mq[30:0];
      end
      if (aq > ZW'(ANGLE_LIMIT)) begin
        ang_nxt = ANGLE_LIMIT[18:0];
      end else if (aq < -ZW'(ANGLE_LIMIT)) begin
        ang_nxt = -ANGLE_LIMIT[18:0];
      end else begin
        ang_nxt = aq[18:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vec_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x_r <= fin.rx;
      res_y_r <= fin.ry;
      mag_r   <= mag_nxt;
      ang_r   <= ang_nxt;
      sat_r   <= fin.sat || msat;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.res_x     = res_x_r;
  assign out_ch.res_y     = res_y_r;
  assign out_ch.magnitude = mag_r;
  assign out_ch.angle     = ang_r;
  assign out_ch.saturated = sat_r;

endmodule
